// ===== design/abbc_pkg.sv =====
// Shared constants and types for the adaptive bang-bang heater controller.
// Depends on nothing; every other file takes names from here by scope.
package abbc_pkg;

    // Field widths
    localparam int TEMP_W   = 14;
    localparam int TARGET_W = 13;
    localparam int DRIVE_W  = 8;
    localparam int POWER_W  = 9;
    localparam int CFG_W    = 13;

    // Control constants, 1/16 degree units where they are temperatures
    localparam int DEAD_TIME_TICKS = 16;
    localparam int MAX_DRIVE       = 150;
    localparam int CONTROL_RANGE   = 320;
    localparam int OFF_TARGET      = 320;
    localparam int HALF_DEGREE     = 8;
    localparam int LIMIT_STEP      = 10;
    localparam int LIMIT_GAP       = 20;
    localparam int LIMIT_FLOOR     = -150;
    localparam int PREV_TEMP_RESET = 320;
    localparam int TARGET_RESET    = 640;

    typedef logic signed [TEMP_W-1:0]  temp_t;
    typedef logic        [DRIVE_W-1:0] drive_t;
    typedef logic signed [POWER_W-1:0] power_t;

    // Configuration register index
    typedef enum logic {
        REG_ENABLE = 1'b0,
        REG_TARGET = 1'b1
    } cfg_index_t;

endpackage

// ===== design/abbc_temp_if.sv =====
// Input channel: one measured temperature per beat.
// Depends on abbc_pkg for the payload type.
interface abbc_temp_if;
    logic           valid;
    logic           ready;
    abbc_pkg::temp_t temperature;

    modport source (output valid, output temperature, input ready);
    modport sink   (input valid, input temperature, output ready);
endinterface

// ===== design/abbc_result_if.sv =====
// Result channel: drive level, held power and both adaptive limits per beat.
// Depends on abbc_pkg for the payload types.
interface abbc_result_if;
    logic             valid;
    logic             ready;
    abbc_pkg::drive_t drive_power;
    abbc_pkg::power_t computed_power;
    abbc_pkg::power_t upper_bound;
    abbc_pkg::power_t lower_bound;

    modport source (output valid, output drive_power, output computed_power,
                    output upper_bound, output lower_bound, input ready);
    modport sink   (input valid, input drive_power, input computed_power,
                    input upper_bound, input lower_bound, output ready);
endinterface

// ===== design/adaptive_bang_bang_heater_control.sv =====
// Adaptive bang-bang heater controller: top level and all datapath logic.
// Depends on abbc_pkg, abbc_temp_if and abbc_result_if.
//
//   channel     | dir | handshake        | payload
//   ------------+-----+------------------+------------------------------------------
//   temp_in     | in  | valid/ready      | temperature (s14, 1/16 C)
//   result_out  | out | valid/ready      | drive_power, computed_power, bounds
//   cfg         | in  | cfg_we only      | cfg_index (enable, target_temp), cfg_data
//
// One beat in, one beat out, one beat per cycle sustained while result_out.ready is high.
// The temperature is captured in an input register; when that beat fires, the
// controller state is updated and the result register loaded in one pass.
// Reset clears the state to a 20 C previous sample, limits 150/0, held power 0,
// enable 0 and a 40 C target.
// A stalled result holds the result register; the input register then holds too,
// and temp_in.ready drops once both are full.
module adaptive_bang_bang_heater_control
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  abbc_pkg::cfg_index_t          cfg_index,
    input  logic [abbc_pkg::CFG_W-1:0]    cfg_data,
    abbc_temp_if.sink                     temp_in,
    abbc_result_if.source                 result_out
);

    localparam int LW = 11;   // limit arithmetic width, covers -170..160
    localparam int EW = 16;   // temperature error width
    localparam int PW = 23;   // predicted temperature width

    // Configuration registers
    logic                              enable_reg;
    logic [abbc_pkg::TARGET_W-1:0]     target_reg;

    // Input stage
    logic                              s1_valid_reg;
    abbc_pkg::temp_t                   s1_temp_reg;

    // Controller state; the held change becomes the prior change of the next sample
    abbc_pkg::temp_t                   prev_temp_reg;
    logic signed [abbc_pkg::TEMP_W:0]  temp_change_reg;
    abbc_pkg::power_t                  upper_limit_reg;
    abbc_pkg::power_t                  lower_limit_reg;
    abbc_pkg::power_t                  held_power_reg;

    // Result stage
    logic                              out_valid_reg;
    abbc_pkg::drive_t                  drive_power_reg;

    // Next values
    logic signed [abbc_pkg::TEMP_W:0]  temp_change_next;
    abbc_pkg::power_t                  upper_limit_next;
    abbc_pkg::power_t                  lower_limit_next;
    abbc_pkg::power_t                  held_power_next;
    abbc_pkg::drive_t                  drive_power_next;

    logic                              out_can;
    logic                              s1_fire;
    logic                              in_fire;

    logic signed [EW-1:0]              err;
    logic signed [PW-1:0]              predicted;
    logic signed [LW-1:0]              up_ext;
    logic signed [LW-1:0]              lo_ext;
    logic signed [LW-1:0]              limit_tmp;
    logic                              peak;
    logic                              trough;

    // Low bound tested first, then high bound, then the floor
    function automatic logic signed [LW-1:0] clamp_low_first(
        input logic signed [LW-1:0] x,
        input logic signed [LW-1:0] lo,
        input logic signed [LW-1:0] hi
    );
        logic signed [LW-1:0] r;
        if (x < lo)
            r = lo;
        else if (x > hi)
            r = hi;
        else
            r = x;
        if (r < LW'(abbc_pkg::LIMIT_FLOOR))
            r = LW'(abbc_pkg::LIMIT_FLOOR);
        return r;
    endfunction

    // Handshake: the result register frees when empty or taken
    assign out_can       = !out_valid_reg || result_out.ready;
    assign s1_fire       = s1_valid_reg && out_can;
    assign temp_in.ready = !s1_valid_reg || out_can;
    assign in_fire       = temp_in.valid && temp_in.ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            target_reg <= abbc_pkg::TARGET_W'(abbc_pkg::TARGET_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                abbc_pkg::REG_ENABLE: enable_reg <= cfg_data[0];
                abbc_pkg::REG_TARGET: target_reg <= cfg_data[abbc_pkg::TARGET_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (temp_in.ready)
            s1_valid_reg <= temp_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_temp_reg <= temp_in.temperature;
    end

    // Controller decision for the captured sample
    always_comb
    begin
        temp_change_next = (abbc_pkg::TEMP_W+1)'(s1_temp_reg)
                         - (abbc_pkg::TEMP_W+1)'(prev_temp_reg);
        err = signed'({{(EW-abbc_pkg::TARGET_W){1'b0}}, target_reg})
            - EW'(s1_temp_reg);
        predicted = PW'(s1_temp_reg)
                  + PW'(temp_change_next) * PW'(abbc_pkg::DEAD_TIME_TICKS);
        up_ext = LW'(upper_limit_reg);
        lo_ext = LW'(lower_limit_reg);
        peak   = (temp_change_reg[abbc_pkg::TEMP_W] == 1'b0)
              && (temp_change_next < 0);
        trough = (temp_change_reg <= 0) && (temp_change_next > 0);

        upper_limit_next = upper_limit_reg;
        lower_limit_next = lower_limit_reg;
        held_power_next  = held_power_reg;
        limit_tmp        = '0;

        if (enable_reg)
        begin
            if (target_reg < abbc_pkg::TARGET_W'(abbc_pkg::OFF_TARGET))
            begin
                held_power_next = '0;
            end
            else if (err > EW'(abbc_pkg::CONTROL_RANGE))
            begin
                held_power_next  = abbc_pkg::POWER_W'(abbc_pkg::MAX_DRIVE);
                upper_limit_next = abbc_pkg::POWER_W'(abbc_pkg::MAX_DRIVE);
                lower_limit_next = '0;
            end
            else if (err < -EW'(abbc_pkg::CONTROL_RANGE))
            begin
                held_power_next = '0;
            end
            else
            begin
                // Nudge the high limit at a peak, the low limit at a trough
                if (peak)
                begin
                    limit_tmp = clamp_low_first(
                        (err < -EW'(abbc_pkg::HALF_DEGREE))
                            ? up_ext - LW'(abbc_pkg::LIMIT_STEP)
                            : up_ext + LW'(abbc_pkg::LIMIT_STEP),
                        lo_ext, LW'(abbc_pkg::MAX_DRIVE));
                    upper_limit_next = abbc_pkg::POWER_W'(limit_tmp);
                end
                else if (trough)
                begin
                    limit_tmp = clamp_low_first(
                        (err > EW'(abbc_pkg::HALF_DEGREE))
                            ? lo_ext + LW'(abbc_pkg::LIMIT_STEP)
                            : lo_ext - LW'(abbc_pkg::LIMIT_STEP),
                        '0, up_ext - LW'(abbc_pkg::LIMIT_GAP));
                    lower_limit_next = abbc_pkg::POWER_W'(limit_tmp);
                end
                // Switch on the temperature predicted a dead time ahead
                if (predicted > signed'({{(PW-abbc_pkg::TARGET_W){1'b0}}, target_reg}))
                    held_power_next = lower_limit_next;
                else
                    held_power_next = upper_limit_next;
            end
        end

        // Applied drive: clamp to 0..MAX_DRIVE, zero while disabled
        if (!enable_reg || held_power_next < 0)
            drive_power_next = '0;
        else if (held_power_next > abbc_pkg::POWER_W'(abbc_pkg::MAX_DRIVE))
            drive_power_next = abbc_pkg::DRIVE_W'(abbc_pkg::MAX_DRIVE);
        else
            drive_power_next = held_power_next[abbc_pkg::DRIVE_W-1:0];
    end

    // State update, one sample per fired beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_temp_reg    <= abbc_pkg::TEMP_W'(abbc_pkg::PREV_TEMP_RESET);
            temp_change_reg  <= '0;
            upper_limit_reg  <= abbc_pkg::POWER_W'(abbc_pkg::MAX_DRIVE);
            lower_limit_reg  <= '0;
            held_power_reg   <= '0;
        end
        else if (s1_fire)
        begin
            prev_temp_reg    <= s1_temp_reg;
            temp_change_reg  <= temp_change_next;
            upper_limit_reg  <= upper_limit_next;
            lower_limit_reg  <= lower_limit_next;
            held_power_reg   <= held_power_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_can)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            drive_power_reg <= drive_power_next;
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.drive_power    = drive_power_reg;
    assign result_out.computed_power = held_power_reg;
    assign result_out.upper_bound    = upper_limit_reg;
    assign result_out.lower_bound    = lower_limit_reg;

    // Checks
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (drive_power_reg <= abbc_pkg::DRIVE_W'(abbc_pkg::MAX_DRIVE)))
        else $error("drive above maximum");

    a_limit_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (upper_limit_reg >= abbc_pkg::POWER_W'(abbc_pkg::LIMIT_FLOOR))
        && (lower_limit_reg >= abbc_pkg::POWER_W'(abbc_pkg::LIMIT_FLOOR)))
        else $error("limit below floor");

    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !enable_reg) |=> (drive_power_reg == '0))
        else $error("drive while disabled");

    a_limits_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_fire && enable_reg) |=> ($stable(upper_limit_reg) && $stable(lower_limit_reg)
                                      && $stable(held_power_reg)))
        else $error("limits moved without an enabled beat");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_can) |=> (s1_valid_reg && $stable(s1_temp_reg)))
        else $error("input stage lost a beat");

endmodule
